FILE: sv/dsps_pkg.sv
// ----------------------------------------------------------------------------
// dsps_pkg
// Types, codes and helpers shared by the dual sensor poll sequencer files.
// ----------------------------------------------------------------------------
package dsps_pkg;

    // command codes carried by each input word
    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_RUN        = 3'd1,
        CMD_HALT       = 3'd2,
        CMD_INIT       = 3'd3,
        CMD_TAKE_FRESH = 3'd4
    } cmd_t;

    // poll phases
    typedef enum logic [2:0] {
        PH_IDLE           = 3'd0,
        PH_MOTION_CHECK   = 3'd1,
        PH_MOTION_READ    = 3'd2,
        PH_PRESSURE_CHECK = 3'd3,
        PH_PRESSURE_READ  = 3'd4
    } phase_t;

    // driver status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // configuration register indexes
    localparam int         CFG_INDEX_W     = 1;
    localparam int         CFG_DATA_W      = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_BMP_PERIOD  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_LIMIT = 1'b1;

    localparam logic [15:0] BMP_PERIOD_RESET  = 16'd25;
    localparam logic [7:0]  ERROR_LIMIT_RESET = 8'd10;
    localparam logic [7:0]  ERR_COUNT_MAX     = 8'd255;

    // input word
    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] now_ms;
        logic        motion_ready;
        logic [1:0]  motion_status;
        logic        pressure_ready;
        logic [1:0]  pressure_status;
    } item_t;

    // result word
    typedef struct packed {
        logic [2:0] phase_out;
        logic       motion_failed;
        logic       pressure_failed;
        logic       start_pulse;
        logic       stop_pulse;
        logic       motion_fetch;
        logic       pressure_fetch;
        logic       fresh_flag;
    } result_t;

    // sequencer state other than the check timestamp
    typedef struct packed {
        phase_t     phase;
        logic       motion_failed;
        logic       pressure_failed;
        logic [7:0] motion_err_count;
        logic [7:0] pressure_err_count;
        logic       fresh;
    } seq_state_t;

    // error tracker outcome for one sensor
    typedef struct packed {
        logic [7:0] count;
        logic       failed;
    } track_t;

    // saturating error count with sticky fault
    function automatic track_t track_status(
        input logic [1:0] status,
        input logic [7:0] count,
        input logic       failed,
        input logic       fatal,
        input logic [7:0] limit
    );
        track_t r;
        r.count  = count;
        r.failed = failed;
        if (!failed) begin
            if (status == ST_ERROR) begin
                if (count != ERR_COUNT_MAX) begin
                    r.count = count + 8'd1;
                end
                if ((r.count >= limit) || fatal) begin
                    r.failed = 1'b1;
                end
            end else if (status == ST_OK) begin
                r.count = '0;
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/dsps_step.sv
// ----------------------------------------------------------------------------
// dsps_step
// Next-state and result logic for one word of the poll sequencer.
// ----------------------------------------------------------------------------
module dsps_step #(
    parameter int TIME_WIDTH = 32
) (
    input  dsps_pkg::item_t      item,
    input  dsps_pkg::seq_state_t cur,
    input  logic [TIME_WIDTH-1:0] last_check,
    input  logic [15:0]           bmp_period_ms,
    input  logic [7:0]            error_limit,
    output dsps_pkg::seq_state_t nxt,
    output logic [TIME_WIDTH-1:0] last_check_next,
    output dsps_pkg::result_t    result
);
    import dsps_pkg::*;

    logic [TIME_WIDTH+31:0] now_ext;
    logic [TIME_WIDTH-1:0]  now_t;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic                   throttled;
    logic                   is_tick;
    logic                   go_enable;
    logic                   go_disable;
    logic                   chk_m;
    logic                   chk_p;
    logic                   fatal;
    logic                   clr_counts;
    logic [7:0]             m_base;
    logic [7:0]             p_base;
    track_t                 m_trk;
    track_t                 p_trk;
    phase_t                 phase_next;
    logic                   fresh_after;

    // time in the configured width, wrapping difference
    assign now_ext   = {{TIME_WIDTH{1'b0}}, item.now_ms};
    assign now_t     = now_ext[TIME_WIDTH-1:0];
    assign elapsed   = now_t - last_check;
    assign throttled = elapsed < {{(TIME_WIDTH-16){1'b0}}, bmp_period_ms};

    assign is_tick    = (item.cmd == CMD_TICK);
    assign go_enable  = (item.cmd == CMD_RUN) && (cur.phase == PH_IDLE);
    assign go_disable = (item.cmd == CMD_HALT) && (cur.phase != PH_IDLE);

    // which status checks run
    always_comb begin
        chk_m      = 1'b0;
        chk_p      = 1'b0;
        fatal      = 1'b0;
        clr_counts = 1'b0;
        case (item.cmd)
            CMD_RUN, CMD_HALT: begin
                chk_m      = 1'b1;
                fatal      = 1'b1;
                clr_counts = 1'b1;
            end
            CMD_INIT: begin
                chk_m = 1'b1;
                chk_p = 1'b1;
                fatal = 1'b1;
            end
            CMD_TICK: begin
                case (cur.phase)
                    PH_MOTION_CHECK, PH_MOTION_READ: chk_m = 1'b1;
                    PH_PRESSURE_CHECK:               chk_p = !throttled;
                    PH_PRESSURE_READ:                chk_p = 1'b1;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // error tracking per sensor
    assign m_base = clr_counts ? 8'd0 : cur.motion_err_count;
    assign p_base = clr_counts ? 8'd0 : cur.pressure_err_count;
    assign m_trk  = track_status(item.motion_status, m_base, cur.motion_failed,
                                 fatal, error_limit);
    assign p_trk  = track_status(item.pressure_status, p_base, cur.pressure_failed,
                                 fatal, error_limit);

    // next phase
    always_comb begin
        phase_next = cur.phase;
        case (item.cmd)
            CMD_RUN: begin
                if (cur.phase == PH_IDLE) begin
                    phase_next = PH_MOTION_CHECK;
                end
            end
            CMD_HALT: begin
                if (cur.phase != PH_IDLE) begin
                    phase_next = PH_IDLE;
                end
            end
            CMD_INIT: phase_next = PH_IDLE;
            CMD_TICK: begin
                case (cur.phase)
                    PH_MOTION_CHECK: begin
                        if (item.motion_ready) begin
                            phase_next = PH_MOTION_READ;
                        end else if (cur.motion_failed) begin
                            phase_next = PH_PRESSURE_CHECK;
                        end
                    end
                    PH_MOTION_READ: begin
                        if (cur.motion_failed || (item.motion_status != ST_BUSY)) begin
                            phase_next = PH_PRESSURE_CHECK;
                        end
                    end
                    PH_PRESSURE_CHECK: begin
                        if (throttled || !item.pressure_ready) begin
                            phase_next = PH_MOTION_CHECK;
                        end else begin
                            phase_next = PH_PRESSURE_READ;
                        end
                    end
                    PH_PRESSURE_READ: begin
                        if (cur.pressure_failed || (item.pressure_status != ST_BUSY)) begin
                            phase_next = PH_MOTION_CHECK;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // fresh flag, cleared when a run or halt command changes the phase and set by a motion read
    always_comb begin
        fresh_after = cur.fresh;
        if (go_enable || go_disable) begin
            fresh_after = 1'b0;
        end else if (is_tick && (cur.phase == PH_MOTION_READ) &&
                     (item.motion_status != ST_BUSY)) begin
            fresh_after = 1'b1;
        end
    end

    // state outputs
    always_comb begin
        nxt.phase              = phase_next;
        nxt.motion_failed      = chk_m ? m_trk.failed : cur.motion_failed;
        nxt.motion_err_count   = chk_m ? m_trk.count : m_base;
        nxt.pressure_failed    = chk_p ? p_trk.failed : cur.pressure_failed;
        nxt.pressure_err_count = chk_p ? p_trk.count : p_base;
        nxt.fresh              = (item.cmd == CMD_TAKE_FRESH) ? 1'b0 : fresh_after;
        last_check_next        = (is_tick && (cur.phase == PH_PRESSURE_CHECK) && !throttled)
                                 ? now_t : last_check;
    end

    // result word
    always_comb begin
        result.phase_out       = phase_next;
        result.motion_failed   = nxt.motion_failed;
        result.pressure_failed = nxt.pressure_failed;
        result.start_pulse     = go_enable && !cur.motion_failed;
        result.stop_pulse      = go_disable && !cur.motion_failed;
        result.motion_fetch    = is_tick && (cur.phase == PH_MOTION_READ);
        result.pressure_fetch  = is_tick && (cur.phase == PH_PRESSURE_READ);
        result.fresh_flag      = fresh_after;
    end

endmodule

FILE: sv/dual_sensor_poll_sequencer.sv
// A word accepted into the input register passes through the step logic into
// the result register. Throughput: one word per cycle unless m_ready stalls the
// output; the whole step fits between the two registers. Back-pressure on
// m_ready stalls the result register, then the input register.
// Reset (aresetn low, synchronous) empties both registers, clears the phase,
// fault bits, error counts, fresh flag and check time, and reloads 25 and 10.
// ----------------------------------------------------------------------------
// dual_sensor_poll_sequencer
// Alternately polls a motion and a pressure sensor with throttled pressure
// checks, error counting with sticky faults and a read-and-clear fresh flag.
// ----------------------------------------------------------------------------
module dual_sensor_poll_sequencer #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  dsps_pkg::item_t                       s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output dsps_pkg::result_t                     m_data,
    input  logic                                  cfg_we,
    input  logic [dsps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [dsps_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import dsps_pkg::*;

    logic                  in_vld_reg;
    logic                  in_vld_next;
    item_t                 in_data_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    result_t               m_data_reg;
    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic [TIME_WIDTH-1:0] last_check_reg;
    logic [TIME_WIDTH-1:0] last_check_next;
    logic [15:0]           bmp_period_reg;
    logic [7:0]            error_limit_reg;
    result_t               step_result;
    logic                  advance;
    logic                  fire;
    logic                  s_take;

    // handshake
    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;
    assign s_take  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        in_vld_next  = s_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        m_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // step logic
    dsps_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .item            (in_data_reg),
        .cur             (state_reg),
        .last_check      (last_check_reg),
        .bmp_period_ms   (bmp_period_reg),
        .error_limit     (error_limit_reg),
        .nxt             (state_next),
        .last_check_next (last_check_next),
        .result          (step_result)
    );

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg                   <= 1'b0;
            m_valid_reg                  <= 1'b0;
            state_reg.phase              <= PH_IDLE;
            state_reg.motion_failed      <= 1'b0;
            state_reg.pressure_failed    <= 1'b0;
            state_reg.motion_err_count   <= '0;
            state_reg.pressure_err_count <= '0;
            state_reg.fresh              <= 1'b0;
            last_check_reg               <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            m_valid_reg <= m_valid_next;
            if (fire) begin
                state_reg      <= state_next;
                last_check_reg <= last_check_next;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bmp_period_reg  <= BMP_PERIOD_RESET;
            error_limit_reg <= ERROR_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BMP_PERIOD:  bmp_period_reg  <= cfg_wdata[15:0];
                REG_ERROR_LIMIT: error_limit_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            m_data_reg <= step_result;
        end
    end

    // a stalled input side means a held result downstream
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready))
        else $error("input stalled without output back-pressure");

    // once both fault bits are set they stay set until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.motion_failed && state_reg.pressure_failed) |=>
        (state_reg.motion_failed && state_reg.pressure_failed))
        else $error("fault bit cleared");

    // a motion fetch leaves the sequencer in motion read or pressure check
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.motion_fetch) |->
        ((m_data_reg.phase_out == PH_MOTION_READ) ||
         (m_data_reg.phase_out == PH_PRESSURE_CHECK)))
        else $error("motion fetch with bad next phase");

    // start and stop are never given together
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.start_pulse && m_data_reg.stop_pulse))
        else $error("start and stop in one word");

endmodule
